FILE: rtl/fcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared widths, state codes and cell control for the FIFO cache directory.
// ----------------------------------------------------------------------------
package fcd_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned CapW = 7;
  localparam int unsigned OccW = 7;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/fcd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_req_if
// Request channel: one block key per transfer.
// ----------------------------------------------------------------------------
interface fcd_req_if;
  logic                       valid;
  logic                       ready;
  logic [fcd_pkg::KeyW-1:0]   block_key;

  modport source (output valid, output block_key, input ready);
  modport sink (input valid, input block_key, output ready);
endinterface
`default_nettype wire

FILE: rtl/fcd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_rsp_if
// Result channel: hit flag and occupancy per transfer.
// ----------------------------------------------------------------------------
interface fcd_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [fcd_pkg::OccW-1:0]   occupancy;

  modport source (output valid, output hit, output occupancy, input ready);
  modport sink (input valid, input hit, input occupancy, output ready);
endinterface
`default_nettype wire

FILE: rtl/fcd_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_cfg_if
// Configuration write channel: capacity register data per transfer.
// ----------------------------------------------------------------------------
interface fcd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [fcd_pkg::CapW-1:0]   capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface
`default_nettype wire

FILE: rtl/fifo_replacement_cache_directory_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_replacement_cache_directory_unit
// Fully associative cache directory with first-in-first-out replacement.
// ----------------------------------------------------------------------------
// ST_IDLE captures the key, ST_CMP runs the registered compare in every cell
// of the chain, and ST_UPD reduces the match bits and, on a miss, shifts the
// new key into the head cell, waiting while an earlier result is unread. The
// cell at position i holds the i-th newest key, so the oldest key sits at
// the end of the occupied run and eviction only means not counting it any
// more. The result sits in an output register, so the next request is taken
// while it waits. Reset clears the occupancy count at once; no clearing pass
// is run. Capacity writes are taken only while no request is in flight.
module fifo_replacement_cache_directory_unit #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fcd_cfg_if.sink          cfg_i,
  fcd_req_if.sink          req_i,
  fcd_rsp_if.source        rsp_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > fcd_pkg::CapW) ? CntW : fcd_pkg::CapW;

  fcd_pkg::state_e              state_q, state_d;
  logic [fcd_pkg::CapW-1:0]     capacity_q;
  logic [fcd_pkg::KeyW-1:0]     lookup_key_q;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         rsp_valid_q, rsp_valid_d;
  logic                         hit_q;
  logic [fcd_pkg::OccW-1:0]     occ_q;

  logic [ENTRIES-1:0]           match;
  logic [fcd_pkg::KeyW-1:0]     chain_key [ENTRIES+1];
  fcd_pkg::cell_ctrl_t          cell_ctrl;

  logic                         req_xfer;
  logic                         upd_go;
  logic                         hit_w;
  logic                         drop;
  logic [CmpW-1:0]              cap_ext, eff_cap, cnt_ext, cnt_new_ext;

  assign req_xfer    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == fcd_pkg::ST_IDLE);
  assign cfg_i.ready = (state_q == fcd_pkg::ST_IDLE);

  assign upd_go = (state_q == fcd_pkg::ST_UPD) && !(rsp_valid_q && !rsp_o.ready);
  assign hit_w  = |match;

  // Clamp capacity into one to ENTRIES.
  always_comb begin
    cap_ext = CmpW'(capacity_q);
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(ENTRIES)) begin
      eff_cap = CmpW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign cnt_ext     = CmpW'(cnt_q);
  assign drop        = (cnt_ext >= eff_cap);
  assign cnt_new_ext = (hit_w || drop) ? cnt_ext : cnt_ext + CmpW'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (upd_go) begin
      cnt_d = cnt_new_ext[CntW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fcd_pkg::ST_IDLE: begin
        if (req_xfer) begin
          state_d = fcd_pkg::ST_CMP;
        end
      end
      fcd_pkg::ST_CMP: begin
        state_d = fcd_pkg::ST_UPD;
      end
      fcd_pkg::ST_UPD: begin
        if (upd_go) begin
          state_d = fcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (upd_go) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign cell_ctrl.cmp_en   = (state_q == fcd_pkg::ST_CMP);
  assign cell_ctrl.shift_en = upd_go && !hit_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcd_pkg::ST_IDLE;
      capacity_q  <= fcd_pkg::CapReset;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        capacity_q <= cfg_i.capacity;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      lookup_key_q <= req_i.block_key;
    end
    if (upd_go) begin
      hit_q <= hit_w;
      occ_q <= cnt_new_ext[fcd_pkg::OccW-1:0];
    end
  end

  assign chain_key[0] = lookup_key_q;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    fcd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .valid_i     (cnt_q > CntW'(i)),
      .lookup_key_i(lookup_key_q),
      .key_i       (chain_key[i]),
      .key_o       (chain_key[i+1]),
      .match_o     (match[i])
    );
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.hit       = hit_q;
  assign rsp_o.occupancy = occ_q;

endmodule
`default_nettype wire

FILE: rtl/fcd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_cell
// One directory slot: holds a key, compares it, passes it down the chain.
// ----------------------------------------------------------------------------
module fcd_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fcd_pkg::cell_ctrl_t       ctrl_i,
  input  logic                      valid_i,
  input  logic [fcd_pkg::KeyW-1:0]  lookup_key_i,
  input  logic [fcd_pkg::KeyW-1:0]  key_i,
  output logic [fcd_pkg::KeyW-1:0]  key_o,
  output logic                      match_o
);

  logic [fcd_pkg::KeyW-1:0] key_q;
  logic                     match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      key_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= valid_i && (key_q == lookup_key_i);
    end
  end

  assign key_o   = key_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

FILE: tb/sv/fcd_directory_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_directory_checker
// Scoreboard for the FIFO cache directory. Tracks capacity writes, predicts
// the hit flag and occupancy of each accepted request from a ring model of
// the directory and compares every accepted result with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module fcd_directory_checker #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  fcd_cfg_if   cfg,
  fcd_req_if   req,
  fcd_rsp_if   rsp,
  output int   fail_count_o,
  output int   outstanding_o
);

  typedef struct packed {
    logic                     hit;
    logic [fcd_pkg::OccW-1:0] occupancy;
  } dir_result_t;

  logic [fcd_pkg::KeyW-1:0] key_slot [ENTRIES];
  logic                     slot_live [ENTRIES];
  int unsigned              head_slot;
  int unsigned              live_count;
  logic [fcd_pkg::CapW-1:0] cap_reg;
  dir_result_t              pending_results [$];
  int                       fail_count;

  function automatic dir_result_t probe_directory(input logic [fcd_pkg::KeyW-1:0] key);
    dir_result_t res;
    int unsigned limit;
    int unsigned slot;
    logic        found;
    found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && key_slot[i] == key) found = 1'b1;
    end
    limit = cap_reg;
    if (limit < 1) limit = 1;
    if (limit > ENTRIES) limit = ENTRIES;
    if (!found) begin
      // drop the oldest entry when full, then append at the tail
      if (live_count >= limit && live_count > 0) begin
        slot_live[head_slot] = 1'b0;
        head_slot = (head_slot + 1) % ENTRIES;
        live_count--;
      end
      slot = (head_slot + live_count) % ENTRIES;
      key_slot[slot] = key;
      slot_live[slot] = 1'b1;
      live_count++;
    end
    res.hit = found;
    res.occupancy = live_count[fcd_pkg::OccW-1:0];
    return res;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dir_result_t exp_res;
    if (!rst_ni) begin
      cap_reg = fcd_pkg::CapReset;
      head_slot = 0;
      live_count = 0;
      fail_count = 0;
      for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          log_failure($sformatf("unexpected result hit=%0d occupancy=%0d",
                                rsp.hit, rsp.occupancy));
        end else begin
          exp_res = pending_results.pop_front();
          if (rsp.hit !== exp_res.hit || rsp.occupancy !== exp_res.occupancy) begin
            log_failure($sformatf("expected hit=%0d occupancy=%0d, got hit=%0d occupancy=%0d",
                                  exp_res.hit, exp_res.occupancy, rsp.hit, rsp.occupancy));
          end
        end
      end
      if (cfg.valid && cfg.ready) cap_reg = cfg.capacity;
      if (req.valid && req.ready) pending_results.push_back(probe_directory(req.block_key));
    end
    fail_count_o <= fail_count;
    outstanding_o <= pending_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the FIFO cache directory. Runs a directed pass
// over capacity extremes and key extremes, then random phases at several
// capacities with keys drawn mostly from a working set, under random
// request gaps and result stalls in all but the last phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned ENTRIES = 64;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int POOL_SIZE = 96;
  localparam int CYCLE_LIMIT = 500000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic quiet;
  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;

  fcd_cfg_if cfg_if ();
  fcd_req_if req_if ();
  fcd_rsp_if rsp_if ();

  fifo_replacement_cache_directory_unit #(.ENTRIES(ENTRIES)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  fcd_directory_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg           (cfg_if),
    .req           (req_if),
    .rsp           (rsp_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL fifo_replacement_cache_directory_unit");
      $finish;
    end
  end

  function automatic logic [fcd_pkg::KeyW-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  task automatic send_key(input logic [fcd_pkg::KeyW-1:0] key);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.block_key <= key;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [fcd_pkg::CapW-1:0] value);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.capacity <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // result stalls
  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    logic [fcd_pkg::KeyW-1:0] pool [POOL_SIZE];
    logic [fcd_pkg::CapW-1:0] caps [PHASES];
    logic [fcd_pkg::KeyW-1:0] key_a;
    logic [fcd_pkg::KeyW-1:0] key_b;
    int                       ws;
    quiet = 1'b0;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.block_key <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.capacity <= fcd_pkg::CapReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    key_a = random_key();
    key_b = random_key();
    write_capacity(7'd1);
    send_key(key_a);
    send_key(key_a);
    send_key(key_b);
    send_key(key_a);
    send_key(key_a);
    write_capacity(7'd0);
    send_key(64'h0);
    send_key(64'h0);
    send_key('1);
    write_capacity(7'd2);
    send_key(64'h5555_5555_5555_5555);
    send_key(64'hAAAA_AAAA_AAAA_AAAA);
    send_key(64'h5555_5555_5555_5555);
    write_capacity(7'd127);
    send_key(64'h8000_0000_0000_0001);
    send_key(64'h0000_0000_0000_0001);
    send_key(64'h0);
    send_key('1);
    send_key(64'h0000_0000_0000_0001);

    caps = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd65, 7'd63,
             fcd_pkg::CapW'($urandom_range(2, 62)),
             7'd2, fcd_pkg::CapW'($urandom_range(0, 127)), 7'd64,
             fcd_pkg::CapW'($urandom_range(3, 40)),
             7'd7};
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = random_key();
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(caps[p]);
      if (p == PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < POOL_SIZE; i++) begin
        if ($urandom_range(0, 1) == 0) pool[i] = random_key();
      end
      ws = $urandom_range(1, POOL_SIZE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 4) == 0) send_key(random_key());
        else send_key(pool[$urandom_range(0, ws - 1)]);
      end
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS fifo_replacement_cache_directory_unit");
    end else begin
      $display("FAIL fifo_replacement_cache_directory_unit");
    end
    $finish;
  end

endmodule
